### hdl/vrt_pkg.sv
`timescale 1ns / 1ps

package vrt_pkg;

    // Internal key width: holds KEY_BITS up to 20 plus sign and one step past the range.
    localparam int KW = 22;

    // Configuration register indexes
    localparam logic [2:0] REG_BOUND_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOUND_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOUND_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOUND_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOUND_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOUND_MAX_Z = 3'd5;
    localparam logic [2:0] REG_FLOOR_EN    = 3'd6;
    localparam logic [2:0] REG_FLOOR_LVL   = 3'd7;

    typedef enum logic [1:0] {
        ST_CELL      = 2'd0,
        ST_OUT_OF_BOX = 2'd1,
        ST_SAME_CELL = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0][15:0] bmin;
        logic [2:0][15:0] bmax;
        logic             floor_en;
        logic [15:0]      floor_lvl;
    } vrt_cfg_t;

    typedef struct packed {
        logic load;          // capture the ray
        logic setup;         // initialize walk state
        logic emit_special;  // emit one status-only result
        logic step;          // emit current cell, advance one cell
        logic at_limit;      // this emission is the last one allowed
    } vrt_cmd_t;

    typedef struct packed {
        logic    out_free;   // output register can take a result this cycle
        status_t special;    // status-only code of the captured ray, ST_CELL if none
        logic    finished;   // walk ends after the current cell
    } vrt_stat_t;

endpackage

### hdl/vrt_ctrl.sv
`timescale 1ns / 1ps

module vrt_ctrl #(
    parameter int MAX_RAY_CELLS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrt_pkg::vrt_stat_t stat,
    output vrt_pkg::vrt_cmd_t  cmd
);
    import vrt_pkg::*;

    localparam int CW = $clog2(MAX_RAY_CELLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        count_next   = count_reg;
        cmd.at_limit = (count_reg == CW'(MAX_RAY_CELLS - 1));
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (stat.out_free)
                begin
                    if (stat.special != ST_CELL)
                    begin
                        cmd.emit_special = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        cmd.setup  = 1'b1;
                        count_next = '0;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.step   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (stat.finished || cmd.at_limit)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (count_reg < CW'(MAX_RAY_CELLS)))
        else $error("cell count past limit");

    a_limit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.at_limit) |=> (state_reg == S_IDLE))
        else $error("walk continued past limit");

    a_special_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SETUP && stat.special != ST_CELL) |-> !cmd.setup)
        else $error("walk started for status-only ray");

endmodule

### hdl/vrt_dp.sv
`timescale 1ns / 1ps

module vrt_dp #(
    parameter int KEY_BITS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vrt_pkg::vrt_cfg_t  cfg,
    input  vrt_pkg::vrt_cmd_t  cmd,
    output vrt_pkg::vrt_stat_t stat,
    input  logic [143:0]       in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [47:0]        out_data,
    output logic               out_last,
    output logic [1:0]         out_user
);
    import vrt_pkg::*;

    localparam int NW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 32;

    typedef logic signed [KW-1:0] key_t;

    function automatic key_t mk_key(input logic [23:0] v);
        logic [23:0] sh;
        key_t        k;
        sh = v >> FRAC_BITS;
        k  = '0;
        for (int i = 0; i < KW; i++)
            if (i < KEY_BITS && i < 24)
                k[i] = sh[i];
        return k;
    endfunction

    function automatic logic in_box(input key_t k0, input key_t k1, input key_t k2,
                                    input vrt_cfg_t c);
        key_t k[3];
        logic ok;
        k[0] = k0;
        k[1] = k1;
        k[2] = k2;
        ok   = 1'b1;
        for (int i = 0; i < 3; i++)
            if (k[i] < $signed({{(KW-16){1'b0}}, c.bmin[i]}) ||
                k[i] > $signed({{(KW-16){1'b0}}, c.bmax[i]}))
                ok = 1'b0;
        return ok;
    endfunction

    // captured ray
    logic [23:0]   org_reg [3];
    logic [23:0]   tgt_reg [3];

    // walk state
    key_t          cur_reg  [3];
    key_t          stop_reg [3];
    logic          neg_reg  [3];
    logic [23:0]   sp_reg   [3];
    logic [PW-1:0] p_reg    [3][3];   // p[a][b] = next_crossing[a] * spacing[b]

    logic          ovalid_reg;
    logic [47:0]   odata_reg;
    logic          olast_reg;
    logic [1:0]    ouser_reg;

    // setup values
    key_t          okey [3];
    key_t          ekey [3];
    logic [23:0]   sp_s [3];
    logic [NW-1:0] nc_s [3];
    key_t          stop_s [3];
    logic          neg_s  [3];
    logic          pos_s  [3];
    status_t       special;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            okey[a]   = mk_key(org_reg[a]);
            ekey[a]   = mk_key(tgt_reg[a]);
            pos_s[a]  = tgt_reg[a] > org_reg[a];
            neg_s[a]  = tgt_reg[a] < org_reg[a];
            sp_s[a]   = '0;
            nc_s[a]   = '0;
            stop_s[a] = '0;
            if (pos_s[a])
            begin
                sp_s[a]   = tgt_reg[a] - org_reg[a];
                nc_s[a]   = (NW'(1) << FRAC_BITS) - NW'(org_reg[a][FRAC_BITS-1:0]);
                stop_s[a] = ekey[a] + key_t'(1);
            end
            else if (neg_s[a])
            begin
                sp_s[a]   = org_reg[a] - tgt_reg[a];
                nc_s[a]   = NW'(org_reg[a][FRAC_BITS-1:0]);
                stop_s[a] = ekey[a] - key_t'(1);
            end
        end
        // floor truncation of downward rays
        if (cfg.floor_en && neg_s[2] &&
            stop_s[2] < $signed({{(KW-16){1'b0}}, cfg.floor_lvl}))
            stop_s[2] = $signed({{(KW-16){1'b0}}, cfg.floor_lvl}) - key_t'(1);

        if (!in_box(okey[0], okey[1], okey[2], cfg))
            special = ST_OUT_OF_BOX;
        else if (okey[0] == ekey[0] && okey[1] == ekey[1] && okey[2] == ekey[2])
            special = ST_SAME_CELL;
        else
            special = ST_CELL;
    end

    // walk step
    logic        e01, e02, e12;
    logic [1:0]  ax;
    key_t        nkey [3];
    logic        finished;

    function automatic logic earlier(input logic [23:0] sa, input logic [23:0] sb,
                                     input logic [PW-1:0] pab, input logic [PW-1:0] pba);
        return (sa != '0) && ((sb == '0) || (pab < pba));
    endfunction

    always_comb
    begin
        e01 = earlier(sp_reg[0], sp_reg[1], p_reg[0][1], p_reg[1][0]);
        e02 = earlier(sp_reg[0], sp_reg[2], p_reg[0][2], p_reg[2][0]);
        e12 = earlier(sp_reg[1], sp_reg[2], p_reg[1][2], p_reg[2][1]);
        if (e01)
            ax = e02 ? 2'd0 : 2'd2;
        else
            ax = e12 ? 2'd1 : 2'd2;
        for (int a = 0; a < 3; a++)
        begin
            nkey[a] = cur_reg[a];
            if (ax == 2'(a))
                nkey[a] = neg_reg[a] ? cur_reg[a] - key_t'(1) : cur_reg[a] + key_t'(1);
        end
        finished = (nkey[ax] == stop_reg[ax]) || !in_box(nkey[0], nkey[1], nkey[2], cfg);
    end

    assign stat.out_free = !ovalid_reg || out_ready;
    assign stat.special  = special;
    assign stat.finished = finished;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            for (int a = 0; a < 3; a++)
            begin
                org_reg[a] <= in_data[24*a +: 24];
                tgt_reg[a] <= in_data[72 + 24*a +: 24];
            end
        if (cmd.setup)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cur_reg[a]  <= okey[a];
                stop_reg[a] <= stop_s[a];
                neg_reg[a]  <= neg_s[a];
                sp_reg[a]   <= sp_s[a];
                for (int b = 0; b < 3; b++)
                    p_reg[a][b] <= (a == b) ? '0 : PW'(nc_s[a]) * PW'(sp_s[b]);
            end
        end
        else if (cmd.step)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cur_reg[a] <= nkey[a];
                for (int b = 0; b < 3; b++)
                    if (ax == 2'(a) && a != b)
                        p_reg[a][b] <= p_reg[a][b] + (PW'(sp_reg[b]) << FRAC_BITS);
            end
        end
        if (cmd.emit_special)
        begin
            odata_reg <= '0;
            olast_reg <= 1'b1;
            ouser_reg <= special;
        end
        else if (cmd.step)
        begin
            odata_reg <= {cur_reg[2][15:0], cur_reg[1][15:0], cur_reg[0][15:0]};
            olast_reg <= finished || cmd.at_limit;
            ouser_reg <= (cmd.at_limit && !finished) ? ST_TRUNCATED : ST_CELL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit_special || cmd.step)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;
    assign out_user  = ouser_reg;

endmodule

### hdl/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Voxel ray traversal: one ray in, its visited cell keys out.
// Flow: a ray is captured on the input transfer and set up in the setup state; each walk step
// then registers one cell, one cell a cycle while the output is free (status-only results
// are registered from the setup state). A new ray is accepted only after the last one ends;
// output back-pressure stalls the walk.
// Reset: rst_n clears control state and output valid, and loads register reset values.

module voxel_ray_traversal #(
    parameter int MAX_RAY_CELLS = 64,
    parameter int KEY_BITS      = 16,
    parameter int FRAC_BITS     = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x, origin_y, origin_z, target_x, target_y, target_z (24 bits each)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cell_x, cell_y, cell_z (16 bits each)
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // status (2 bits)
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import vrt_pkg::*;

    vrt_cfg_t  cfg_reg, cfg_next;
    vrt_cmd_t  cmd;
    vrt_stat_t stat;

    // register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BOUND_MIN_X: cfg_next.bmin[0]  = cfg_data;
                REG_BOUND_MIN_Y: cfg_next.bmin[1]  = cfg_data;
                REG_BOUND_MIN_Z: cfg_next.bmin[2]  = cfg_data;
                REG_BOUND_MAX_X: cfg_next.bmax[0]  = cfg_data;
                REG_BOUND_MAX_Y: cfg_next.bmax[1]  = cfg_data;
                REG_BOUND_MAX_Z: cfg_next.bmax[2]  = cfg_data;
                REG_FLOOR_EN:    cfg_next.floor_en = cfg_data[0];
                REG_FLOOR_LVL:   cfg_next.floor_lvl = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bmin      <= '0;
            cfg_reg.bmax      <= '1;   // full box
            cfg_reg.floor_en  <= 1'b0;
            cfg_reg.floor_lvl <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer: idle -> setup -> walk, one cell per transfer slot
    vrt_ctrl #(
        .MAX_RAY_CELLS (MAX_RAY_CELLS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ray setup, incremental crossing compare, output register
    vrt_dp #(
        .KEY_BITS  (KEY_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import vrt_pkg::*;

    localparam int RAY_CELL_CAP = 64;
    localparam int FRAC_W       = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;

    // one expected output transfer
    typedef struct {
        bit [15:0] x;
        bit [15:0] y;
        bit [15:0] z;
        bit        last;
        status_t   st;
    } cell_rec_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // origin_x, origin_y, origin_z, target_x, target_y, target_z (24 bits each)
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // cell_x, cell_y, cell_z (16 bits each)
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;
    // status (2 bits)
    logic [1:0]   m_axis_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    // shadow copy of the configuration registers
    int        box_lo [3];
    int        box_hi [3];
    bit        floor_on;
    int        floor_lvl;

    cell_rec_t cell_q [$];
    int        errors;
    int        cycles;
    bit        calm;          // no idling on either side
    int        rdy_hold;

    voxel_ray_traversal u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------
    function automatic bit key_in_box(input int k [3]);
        for (int i = 0; i < 3; i++)
            if (k[i] < box_lo[i] || k[i] > box_hi[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // axis a crosses its next border strictly before axis b
    function automatic bit crosses_first(input int a, input int b,
                                         input longint unsigned nx [3],
                                         input longint unsigned sp [3]);
        if (sp[a] == 0)
            return 1'b0;
        if (sp[b] == 0)
            return 1'b1;
        return nx[a] * sp[b] < nx[b] * sp[a];
    endfunction

    function automatic void push_cell(input int k [3], input bit last, input status_t st);
        cell_rec_t r;
        r.x    = k[0][15:0];
        r.y    = k[1][15:0];
        r.z    = k[2][15:0];
        r.last = last;
        r.st   = st;
        cell_q.push_back(r);
    endfunction

    // Expands one ray into the cells it visits and queues them.
    function automatic void walk_ray(input bit [23:0] org [3], input bit [23:0] dst [3]);
        int                ok [3];
        int                ek [3];
        int                cur [3];
        int                dir [3];
        int                stp [3];
        int                zero3 [3];
        longint unsigned   nx [3];
        longint unsigned   sp [3];
        int                path [RAY_CELL_CAP+1][3];
        int                n;
        int                ax;
        int                shown;
        zero3 = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            ok[i] = org[i] >> FRAC_W;
            ek[i] = dst[i] >> FRAC_W;
        end
        if (!key_in_box(ok))
        begin
            push_cell(zero3, 1'b1, ST_OUT_OF_BOX);
            return;
        end
        if (ok == ek)
        begin
            push_cell(zero3, 1'b1, ST_SAME_CELL);
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            cur[i] = ok[i];
            if (dst[i] > org[i])
            begin
                dir[i] = 1;
                sp[i]  = dst[i] - org[i];
                nx[i]  = 256 - org[i][7:0];
                stp[i] = ek[i] + 1;
            end
            else if (dst[i] < org[i])
            begin
                dir[i] = -1;
                sp[i]  = org[i] - dst[i];
                nx[i]  = org[i][7:0];
                stp[i] = ek[i] - 1;
            end
            else
            begin
                dir[i] = 0;
                sp[i]  = 0;
                nx[i]  = 0;
                stp[i] = 0;
            end
        end
        // downward rays end at the floor: their stop key is one cell under it
        if (floor_on && dir[2] < 0 && stp[2] < floor_lvl)
            stp[2] = floor_lvl - 1;
        n = 0;
        forever
        begin
            if (!key_in_box(cur))
                break;
            path[n] = cur;
            n++;
            if (n > RAY_CELL_CAP)
                break;
            // ties go to the later axis
            if (crosses_first(0, 1, nx, sp))
                ax = crosses_first(0, 2, nx, sp) ? 0 : 2;
            else
                ax = crosses_first(1, 2, nx, sp) ? 1 : 2;
            cur[ax] += dir[ax];
            nx[ax]  += 256;
            if (cur[ax] == stp[ax])
                break;
        end
        shown = (n > RAY_CELL_CAP) ? RAY_CELL_CAP : n;
        for (int i = 0; i < shown; i++)
            push_cell(path[i], i == shown - 1,
                      (i == shown - 1 && n > RAY_CELL_CAP) ? ST_TRUNCATED : ST_CELL);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: a transfer happens at the posedge after this negedge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        cell_rec_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cell_q.size() == 0)
            begin
                $display("%0t: unexpected result cell=%h last=%b status=%0d", $time,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = cell_q.pop_front();
                if (m_axis_tdata[15:0] !== e.x)
                begin
                    $display("%0t: cell_x exp %0d got %0d", $time, e.x, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== e.y)
                begin
                    $display("%0t: cell_y exp %0d got %0d", $time, e.y, m_axis_tdata[31:16]);
                    errors++;
                end
                if (m_axis_tdata[47:32] !== e.z)
                begin
                    $display("%0t: cell_z exp %0d got %0d", $time, e.z, m_axis_tdata[47:32]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $display("%0t: last exp %b got %b", $time, e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rdy_hold      <= 0;
        end
        else if (calm)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (rdy_hold > 0)
        begin
            rdy_hold <= rdy_hold - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            rdy_hold      <= $urandom_range(0, 9);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rdy_hold      <= $urandom_range(0, 6);
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    task automatic send_ray(input bit [23:0] org [3], input bit [23:0] dst [3]);
        bit took;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst[2], dst[1], dst[0], org[2], org[1], org[0]};
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        walk_ray(org, dst);
    endtask

    // stop sending and let every expected cell come out
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (cell_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BOUND_MIN_X: box_lo[0] = val & 16'hFFFF;
            REG_BOUND_MIN_Y: box_lo[1] = val & 16'hFFFF;
            REG_BOUND_MIN_Z: box_lo[2] = val & 16'hFFFF;
            REG_BOUND_MAX_X: box_hi[0] = val & 16'hFFFF;
            REG_BOUND_MAX_Y: box_hi[1] = val & 16'hFFFF;
            REG_BOUND_MAX_Z: box_hi[2] = val & 16'hFFFF;
            REG_FLOOR_EN:    floor_on  = val[0];
            REG_FLOOR_LVL:   floor_lvl = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_box(input int lo, input int hi);
        write_reg(REG_BOUND_MIN_X, lo);
        write_reg(REG_BOUND_MIN_Y, lo);
        write_reg(REG_BOUND_MIN_Z, lo);
        write_reg(REG_BOUND_MAX_X, hi);
        write_reg(REG_BOUND_MAX_Y, hi);
        write_reg(REG_BOUND_MAX_Z, hi);
    endtask

    task automatic ray(input bit [23:0] ox, input bit [23:0] oy, input bit [23:0] oz,
                       input bit [23:0] tx, input bit [23:0] ty, input bit [23:0] tz);
        bit [23:0] org [3];
        bit [23:0] dst [3];
        org = '{ox, oy, oz};
        dst = '{tx, ty, tz};
        send_ray(org, dst);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset box covers everything: same cell, extremes, ties, single axis
    task automatic test_plain_walks;
        ray(0, 0, 0, 0, 0, 0);
        ray(24'h000010, 24'h0000F0, 24'h000001, 24'h0000FF, 24'h000000, 24'h000080);
        ray(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        ray(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0);
        ray(24'h80, 24'h80, 24'h80, 24'h380, 24'h280, 24'h180);
        ray(0, 0, 0, 24'h200, 24'h200, 24'h200);          // exact three-way ties
        ray(24'h40, 24'h40, 24'h40, 24'h640, 24'h40, 24'h40);
        ray(24'h540, 24'h300, 24'h2C0, 24'h10, 24'h20, 24'h00);  // ends at key 0
        ray(24'hFFFF00, 24'h100, 24'hFFFFFF, 24'hFFFC00, 24'h500, 24'hFFFA00);
        drain();
    endtask

    // origin outside, leaving the box, empty box
    task automatic test_box;
        set_box(10, 20);
        ray(24'h500, 24'hC00, 24'hC00, 24'hE00, 24'hE00, 24'hE00);
        ray(24'hC00, 24'hC00, 24'h1600, 24'hC00, 24'hC00, 24'hC00);
        ray(24'hC80, 24'hC80, 24'hC80, 24'h2080, 24'hD00, 24'hC00);
        ray(24'h1480, 24'h1480, 24'h1480, 24'h200, 24'h1000, 24'h1300);
        drain();
        write_reg(REG_BOUND_MIN_X, 30);
        ray(24'h1500, 24'h1000, 24'h1000, 24'h1600, 24'h1000, 24'h1000);
        drain();
        set_box(0, 65535);
    endtask

    // floor truncation on downward rays, both floor extremes
    task automatic test_floor;
        write_reg(REG_FLOOR_EN, 1);
        write_reg(REG_FLOOR_LVL, 15);
        ray(24'h1480, 24'h1480, 24'h1A80, 24'h1480, 24'h1600, 24'h0200);
        ray(24'h1480, 24'h1480, 24'h0C80, 24'h1480, 24'h1600, 24'h0200);
        ray(24'h1480, 24'h1480, 24'h0480, 24'h1480, 24'h1600, 24'h1200);
        drain();
        write_reg(REG_FLOOR_LVL, 65535);
        ray(24'h80, 24'h80, 24'hFFFF80, 24'h380, 24'h80, 24'hFFF000);
        drain();
        write_reg(REG_FLOOR_LVL, 0);
        ray(24'h80, 24'h80, 24'h380, 24'h80, 24'h80, 24'h000);
        drain();
        write_reg(REG_FLOOR_EN, 0);
    endtask

    function automatic bit [23:0] near_coord(input int key, input int cells);
        int v;
        v = key * 256 + $urandom_range(0, 255) + ($urandom_range(0, 2 * cells) - cells) * 256;
        if (v < 0)
            v = $urandom_range(0, 255);
        if (v > 24'hFFFFFF)
            v = 24'hFFFFFF - $urandom_range(0, 255);
        return v[23:0];
    endfunction

    // random boxes, floors and rays; mostly short rays starting in the box
    task automatic test_random_rays(input int phases, input int per_phase);
        int        base;
        int        span;
        bit [23:0] org [3];
        bit [23:0] dst [3];
        for (int p = 0; p < phases; p++)
        begin
            base = $urandom_range(0, 65535 - 64);
            span = $urandom_range(2, 40);
            set_box(base, base + span);
            write_reg(REG_FLOOR_EN, $urandom_range(0, 1));
            write_reg(REG_FLOOR_LVL, base + $urandom_range(0, span));
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        org[i] = $urandom;
                        dst[i] = $urandom;
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        org[i] = near_coord(base + $urandom_range(0, span), 0);
                        dst[i] = ($urandom_range(0, 5) == 0) ? org[i]
                               : near_coord(org[i] >> FRAC_W, 12);
                    end
                end
                send_ray(org, dst);
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_BOUND_MIN_X;
        cfg_data      = '0;
        calm          = 1'b0;
        errors        = 0;
        cycles        = 0;
        box_lo        = '{0, 0, 0};
        box_hi        = '{65535, 65535, 65535};
        floor_on      = 1'b0;
        floor_lvl     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_walks();
        test_box();
        test_floor();
        test_random_rays(4, 17);
        calm = 1'b1;            // closing stretch without idling
        test_random_rays(1, 15);
        set_box(0, 65535);
        test_plain_walks();
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
